/* rtl/core/bba_pkg.sv */
// Shared types and constants for the buddy block allocator.
// No dependencies; imported by the top level.
package bba_pkg;

  localparam int NUM_BLOCKS = 64;
  localparam int LOG_LEAVES = $clog2(NUM_BLOCKS + 1) - 1;
  localparam int LEAVES     = 1 << LOG_LEAVES;
  localparam int NODES      = 2 * LEAVES - 1;
  localparam int RAM_DEPTH  = 2 * LEAVES;
  localparam int NODE_W     = LOG_LEAVES + 1;
  localparam int LVL_W      = $clog2(LOG_LEAVES + 1);
  localparam int K_W        = LOG_LEAVES + 1;
  localparam int BS_W       = 17;
  localparam int OFF_W      = 26;
  localparam int REQ_W      = 26;
  localparam int SPAN_W     = BS_W + LOG_LEAVES;
  localparam int WIDE_W     = ((SPAN_W > OFF_W) ? SPAN_W : OFF_W) + 1;
  localparam int PROD_W     = K_W + BS_W;
  localparam int BS_MAX     = 65536;
  localparam int BS_RESET   = 4096;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    NS_FREE  = 2'd0,
    NS_SPLIT = 2'd1,
    NS_ALLOC = 2'd2
  } node_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_BADOFF = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SIZE,
    S_A_RD,
    S_A_CHK,
    S_A_MARK,
    S_A_MUL,
    S_R_RD,
    S_R_CHK,
    S_R_FREE,
    S_M_RD,
    S_M_CHK,
    S_DONE
  } state_t;

endpackage

/* rtl/core/bba_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/buddy_block_allocator.sv */
// Buddy block allocator; node states live in one 2-bit RAM, one access per cycle.
// Allocate: a size search, then a RAM read and check per tree level probed
//   (restart from the root after each blocked candidate), mark writes up to the root, a multiply.
// Release: a read and check per level walked, a free write, a buddy read and check per merge.
// One transaction at a time.
// Reset (rst, synchronous): a clearing pass writes every node free.
module buddy_block_allocator
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [BS_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [REQ_W-1:0]  request_bytes,
  input  logic [OFF_W-1:0]  release_offset,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [OFF_W-1:0]  block_offset
);

  state_t state, state_next;

  logic [BS_W-1:0]   min_block_bytes;
  logic [BS_W-1:0]   bs_eff;
  logic [NODE_W-1:0] clr_addr, clr_addr_next;
  logic [REQ_W-1:0]  req, req_next;
  logic [OFF_W-1:0]  off, off_next;
  logic [LVL_W-1:0]  lvl_d, lvl_d_next;
  logic [LVL_W-1:0]  exp_e, exp_e_next;
  logic [LVL_W-1:0]  cur_j, cur_j_next;
  logic [K_W-1:0]    cand_k, cand_k_next;
  logic [NODE_W-1:0] node, node_next;
  logic              mark_first, mark_first_next;
  logic [WIDE_W-1:0] start, start_next;
  logic [WIDE_W-1:0] span, span_next;
  logic [1:0]        res_status, res_status_next;
  logic [OFF_W-1:0]  res_offset, res_offset_next;

  // RAM port
  logic              we;
  logic [NODE_W-1:0] waddr, raddr;
  logic [1:0]        wdata, rdata;

  // Helpers
  logic [WIDE_W-1:0] span0, size_cap, half, mid;
  logic [LVL_W-1:0]  shamt;
  logic [K_W-1:0]    path_pre, k_limit, k_skip, k_inc;
  logic [NODE_W-1:0] path_node, target_node, parent, sibling;
  logic [K_W-1:0]    leaf_idx;
  logic [PROD_W-1:0] prod;

  // Clamp block size: zero reads as one byte, large values saturate.
  always_comb begin
    if (min_block_bytes == '0) begin
      bs_eff = BS_W'(1);
    end else if (min_block_bytes > BS_W'(BS_MAX)) begin
      bs_eff = BS_W'(BS_MAX);
    end else begin
      bs_eff = min_block_bytes;
    end
  end

  assign span0    = WIDE_W'(bs_eff) << LOG_LEAVES;
  assign size_cap = WIDE_W'(bs_eff) << exp_e;
  assign half     = span >> 1;
  assign mid      = start + half;

  // Node on the root-to-candidate path at depth cur_j.
  assign shamt       = lvl_d - cur_j;
  assign path_pre    = cand_k >> shamt;
  assign path_node   = ((NODE_W'(1) << cur_j) - NODE_W'(1)) + NODE_W'(path_pre);
  assign target_node = ((NODE_W'(1) << lvl_d) - NODE_W'(1)) + NODE_W'(cand_k);
  assign k_limit     = K_W'(1) << lvl_d;
  assign k_skip      = (path_pre + K_W'(1)) << shamt;
  assign k_inc       = cand_k + K_W'(1);

  assign parent  = (node - NODE_W'(1)) >> 1;
  assign sibling = node[0] ? (node + NODE_W'(1)) : (node - NODE_W'(1));

  assign leaf_idx = cand_k << exp_e;
  assign prod     = PROD_W'(leaf_idx) * PROD_W'(bs_eff);

  assign in_stall = (state != S_IDLE);

  bba_ram #(
    .WIDTH (2),
    .DEPTH (RAM_DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    req_next        = req;
    off_next        = off;
    lvl_d_next      = lvl_d;
    exp_e_next      = exp_e;
    cur_j_next      = cur_j;
    cand_k_next     = cand_k;
    node_next       = node;
    mark_first_next = mark_first;
    start_next      = start;
    span_next       = span;
    res_status_next = res_status;
    res_offset_next = res_offset;
    we              = 1'b0;
    waddr           = node;
    wdata           = NS_FREE;
    raddr           = node;

    unique case (state)
      S_CLEAR: begin
        // Sweep every RAM entry to free.
        we            = 1'b1;
        waddr         = clr_addr;
        clr_addr_next = clr_addr + NODE_W'(1);
        if (clr_addr == NODE_W'(RAM_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_ALLOC) begin
            req_next   = request_bytes;
            exp_e_next = '0;
            state_next = S_SIZE;
          end else if (WIDE_W'(release_offset) >= span0) begin
            res_status_next = ST_BADOFF;
            res_offset_next = '0;
            state_next      = S_DONE;
          end else begin
            off_next   = release_offset;
            start_next = '0;
            span_next  = span0;
            node_next  = '0;
            cur_j_next = '0;
            state_next = S_R_RD;
          end
        end
      end

      S_SIZE: begin
        // Find the smallest power-of-two block count that covers the request.
        if (req == '0) begin
          res_status_next = ST_NOFIT;
          res_offset_next = '0;
          state_next      = S_DONE;
        end else if (WIDE_W'(req) <= size_cap) begin
          lvl_d_next  = LVL_W'(LOG_LEAVES) - exp_e;
          cand_k_next = '0;
          cur_j_next  = '0;
          state_next  = S_A_RD;
        end else if (exp_e == LVL_W'(LOG_LEAVES)) begin
          res_status_next = ST_NOFIT;
          res_offset_next = '0;
          state_next      = S_DONE;
        end else begin
          exp_e_next = exp_e + LVL_W'(1);
        end
      end

      S_A_RD: begin
        raddr      = path_node;
        state_next = S_A_CHK;
      end

      S_A_CHK: begin
        if (rdata == NS_FREE) begin
          // Free at the target level, or a free ancestor whose subtree is all free.
          node_next       = target_node;
          mark_first_next = 1'b1;
          state_next      = S_A_MARK;
        end else if (cur_j == lvl_d || rdata == NS_ALLOC) begin
          // Blocked: skip this candidate or the whole allocated subtree.
          cand_k_next = (cur_j == lvl_d) ? k_inc : k_skip;
          cur_j_next  = '0;
          if (((cur_j == lvl_d) ? k_inc : k_skip) >= k_limit) begin
            res_status_next = ST_NOFIT;
            res_offset_next = '0;
            state_next      = S_DONE;
          end else begin
            state_next = S_A_RD;
          end
        end else begin
          cur_j_next = cur_j + LVL_W'(1);
          state_next = S_A_RD;
        end
      end

      S_A_MARK: begin
        // Mark the grant, then split every ancestor up to the root.
        we              = 1'b1;
        waddr           = node;
        wdata           = mark_first ? NS_ALLOC : NS_SPLIT;
        mark_first_next = 1'b0;
        if (node == '0) begin
          state_next = S_A_MUL;
        end else begin
          node_next = parent;
        end
      end

      S_A_MUL: begin
        res_status_next = ST_OK;
        res_offset_next = OFF_W'(prod);
        state_next      = S_DONE;
      end

      S_R_RD: begin
        raddr      = node;
        state_next = S_R_CHK;
      end

      S_R_CHK: begin
        if (rdata == NS_ALLOC) begin
          if (WIDE_W'(off) == start) begin
            state_next = S_R_FREE;
          end else begin
            res_status_next = ST_BADOFF;
            res_offset_next = '0;
            state_next      = S_DONE;
          end
        end else if (rdata == NS_FREE || cur_j == LVL_W'(LOG_LEAVES)) begin
          res_status_next = ST_BADOFF;
          res_offset_next = '0;
          state_next      = S_DONE;
        end else begin
          // Descend toward the offset.
          span_next  = half;
          cur_j_next = cur_j + LVL_W'(1);
          if (WIDE_W'(off) < mid) begin
            node_next = (node << 1) + NODE_W'(1);
          end else begin
            node_next  = (node << 1) + NODE_W'(2);
            start_next = mid;
          end
          state_next = S_R_RD;
        end
      end

      S_R_FREE: begin
        we              = 1'b1;
        waddr           = node;
        wdata           = NS_FREE;
        res_status_next = ST_OK;
        res_offset_next = off;
        state_next      = (node == '0) ? S_DONE : S_M_RD;
      end

      S_M_RD: begin
        raddr      = sibling;
        state_next = S_M_CHK;
      end

      S_M_CHK: begin
        // Merge with the buddy while both halves are free.
        if (rdata == NS_FREE) begin
          we         = 1'b1;
          waddr      = parent;
          wdata      = NS_FREE;
          node_next  = parent;
          state_next = (parent == '0) ? S_DONE : S_M_RD;
        end else begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      out_valid       <= 1'b0;
      min_block_bytes <= BS_W'(BS_RESET);
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      if (cfg_we) begin
        min_block_bytes <= cfg_wdata;
      end
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    req        <= req_next;
    off        <= off_next;
    lvl_d      <= lvl_d_next;
    exp_e      <= exp_e_next;
    cur_j      <= cur_j_next;
    cand_k     <= cand_k_next;
    node       <= node_next;
    mark_first <= mark_first_next;
    start      <= start_next;
    span       <= span_next;
    res_status <= res_status_next;
    res_offset <= res_offset_next;
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status       <= res_status;
      block_offset <= res_offset;
    end
  end

`ifndef ASSERT_OFF
  a_fail_zero_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> block_offset == '0)
    else $error("failed transaction carries a nonzero offset");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> state == S_CLEAR)
    else $error("reset did not start the clearing pass");

  a_walk_in_tree: assert property (@(posedge clk) disable iff (rst)
    state == S_R_RD |-> node < NODE_W'(NODES))
    else $error("release walk left the node tree");

  a_probe_after_read: assert property (@(posedge clk) disable iff (rst)
    state == S_A_CHK |-> $past(state) == S_A_RD)
    else $error("probe check without a preceding RAM read");
`endif

endmodule
